/* hdl/agac_pkg.sv */
package agac_pkg;

  localparam int FIELD_BITS = 16;
  localparam int CFG_BITS = 8;
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  typedef enum logic [1:0] {
    REG_MATCH    = 2'd0,
    REG_MISMATCH = 2'd1,
    REG_GAP_OPEN = 2'd2,
    REG_GAP_EXT  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    TR_DIAG       = 3'd0,
    TR_LEFT_OPEN  = 3'd1,
    TR_LEFT_EXT   = 3'd2,
    TR_UP_OPEN    = 3'd3,
    TR_UP_EXT     = 3'd4
  } trace_t;

  typedef struct packed {
    logic signed [CFG_BITS-1:0] match_award;
    logic signed [CFG_BITS-1:0] mismatch_penalty;
    logic signed [CFG_BITS-1:0] gap_open;
    logic signed [CFG_BITS-1:0] gap_extend;
  } cfg_t;

  localparam logic signed [CFG_BITS-1:0] MATCH_RESET    = 8'sd1;
  localparam logic signed [CFG_BITS-1:0] MISMATCH_RESET = -8'sd1;
  localparam logic signed [CFG_BITS-1:0] GAP_OPEN_RESET = -8'sd2;
  localparam logic signed [CFG_BITS-1:0] GAP_EXT_RESET  = -8'sd1;

  typedef struct packed {
    logic [1:0]                   ref_base;
    logic [1:0]                   query_base;
    logic signed [FIELD_BITS-1:0] upper_score;
    logic signed [FIELD_BITS-1:0] up_ix;
    logic                         restart;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] cell_score;
    logic signed [FIELD_BITS-1:0] ix_out;
    logic signed [FIELD_BITS-1:0] iy_out;
    trace_t                       trace_code;
    logic signed [FIELD_BITS-1:0] best_score;
  } out_item_t;

endpackage

/* hdl/agac_if.sv */
interface agac_in_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           ref_base;
  logic [1:0]           query_base;
  logic signed [15:0]   upper_score;
  logic signed [15:0]   up_ix;
  logic                 restart;

  modport source (output valid, ref_base, query_base, upper_score, up_ix, restart,
                  input ready);
  modport sink (input valid, ref_base, query_base, upper_score, up_ix, restart,
                output ready);
endinterface

interface agac_out_if;
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   cell_score;
  logic signed [15:0]   ix_out;
  logic signed [15:0]   iy_out;
  logic [2:0]           trace_code;
  logic signed [15:0]   best_score;

  modport source (output valid, cell_score, ix_out, iy_out, trace_code, best_score,
                  input ready);
  modport sink (input valid, cell_score, ix_out, iy_out, trace_code, best_score,
                output ready);
endinterface

/* hdl/agac_cfg.sv */
module agac_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [agac_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [agac_pkg::DATA_BITS-1:0]      pwdata,
  output logic [agac_pkg::DATA_BITS-1:0]      prdata,
  output logic                                pready,
  output agac_pkg::cfg_t                      cfg
);

  agac_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = agac_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_award      <= agac_pkg::MATCH_RESET;
      cfg.mismatch_penalty <= agac_pkg::MISMATCH_RESET;
      cfg.gap_open         <= agac_pkg::GAP_OPEN_RESET;
      cfg.gap_extend       <= agac_pkg::GAP_EXT_RESET;
    end else if (wr_en) begin
      unique case (idx)
        agac_pkg::REG_MATCH:    cfg.match_award      <= pwdata[7:0];
        agac_pkg::REG_MISMATCH: cfg.mismatch_penalty <= pwdata[7:0];
        agac_pkg::REG_GAP_OPEN: cfg.gap_open         <= pwdata[7:0];
        agac_pkg::REG_GAP_EXT:  cfg.gap_extend       <= pwdata[7:0];
        default:                cfg.gap_extend       <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      agac_pkg::REG_MATCH:    prdata = 32'(cfg.match_award);
      agac_pkg::REG_MISMATCH: prdata = 32'(cfg.mismatch_penalty);
      agac_pkg::REG_GAP_OPEN: prdata = 32'(cfg.gap_open);
      agac_pkg::REG_GAP_EXT:  prdata = 32'(cfg.gap_extend);
      default:                prdata = '0;
    endcase
  end

endmodule

/* hdl/agac_cell.sv */
module agac_cell #(
  parameter int SCORE_BITS = 16
) (
  input  agac_pkg::cfg_t                 cfg,
  input  logic [1:0]                     ref_base,
  input  logic [1:0]                     query_base,
  input  logic                           restart,
  input  logic signed [SCORE_BITS-1:0]   upper_score,
  input  logic signed [SCORE_BITS-1:0]   up_ix,
  input  logic signed [SCORE_BITS-1:0]   left_score,
  input  logic signed [SCORE_BITS-1:0]   left_iy,
  input  logic signed [SCORE_BITS-1:0]   diag_score,
  input  logic signed [SCORE_BITS-1:0]   running_best,
  output logic signed [SCORE_BITS-1:0]   cell_score,
  output logic signed [SCORE_BITS-1:0]   ix,
  output logic signed [SCORE_BITS-1:0]   iy,
  output logic signed [SCORE_BITS-1:0]   best_next,
  output agac_pkg::trace_t               trace_code
);

  localparam logic signed [SCORE_BITS-1:0] MostNeg = {1'b1, {(SCORE_BITS-1){1'b0}}};

  logic signed [SCORE_BITS-1:0] ls, liy, ds, rb;
  logic signed [SCORE_BITS-1:0] a1, a2, a3, a4, gap, diag;
  logic signed [agac_pkg::CFG_BITS-1:0] diag_add;
  agac_pkg::trace_t tb_iy, tb_ix, tb_gap;

  // restart clears the kept state ahead of this cell
  assign ls  = restart ? '0 : left_score;
  assign liy = restart ? '0 : left_iy;
  assign ds  = restart ? '0 : diag_score;
  assign rb  = restart ? MostNeg : running_best;

  assign a1 = ls + SCORE_BITS'(cfg.gap_open);
  assign a2 = liy + SCORE_BITS'(cfg.gap_extend);
  assign a3 = upper_score + SCORE_BITS'(cfg.gap_open);
  assign a4 = up_ix + SCORE_BITS'(cfg.gap_extend);

  assign diag_add = (ref_base == query_base) ? cfg.match_award : cfg.mismatch_penalty;
  assign diag     = ds + SCORE_BITS'(diag_add);

  // extend wins ties inside a gap, vertical wins between gaps, diagonal wins overall
  always_comb begin
    iy    = (a1 > a2) ? a1 : a2;
    tb_iy = (a1 > a2) ? agac_pkg::TR_LEFT_OPEN : agac_pkg::TR_LEFT_EXT;
    ix    = (a3 > a4) ? a3 : a4;
    tb_ix = (a3 > a4) ? agac_pkg::TR_UP_OPEN : agac_pkg::TR_UP_EXT;
    gap    = (iy > ix) ? iy : ix;
    tb_gap = (iy > ix) ? tb_iy : tb_ix;
    cell_score = (gap > diag) ? gap : diag;
    trace_code = (gap > diag) ? tb_gap : agac_pkg::TR_DIAG;
    best_next  = (cell_score > rb) ? cell_score : rb;
  end

endmodule

/* hdl/affine_gap_alignment_cell_core.sv */
// One processing cell of an affine-gap global alignment array. It takes one item per clock
// and returns one result per item from a result register: the accepted item lands in an input
// register, and a single add-compare-select path (gap open/extend, diagonal match or mismatch,
// best of three, running best) feeds the result register and the cell's kept state at the
// same edge. Back-to-back items therefore chain through the left score and left gap at one
// item per cycle; throughput drops only while the result side holds ready low.
// A restart flag on an item clears the kept state before that item is scored. Scores are
// computed at SCORE_BITS bits with two's complement wrap. Gap and award values are written
// through the APB port at byte addresses 0, 4, 8 and 12.
module affine_gap_alignment_cell_core #(
  parameter int SCORE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  agac_in_if.sink                             in_ch,
  agac_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [agac_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [agac_pkg::DATA_BITS-1:0]      pwdata,
  output logic [agac_pkg::DATA_BITS-1:0]      prdata,
  output logic                                pready
);

  localparam logic signed [SCORE_BITS-1:0] MostNeg = {1'b1, {(SCORE_BITS-1){1'b0}}};

  agac_pkg::cfg_t      cfg;
  agac_pkg::in_item_t  in_q;
  agac_pkg::out_item_t out_q;
  logic                in_v;
  logic                out_v;
  logic                take;
  logic                move;

  logic signed [SCORE_BITS-1:0] left_score, left_iy, diag_score, running_best;
  logic signed [SCORE_BITS-1:0] up_s, up_x;
  logic signed [SCORE_BITS-1:0] cell_score, ix, iy, best_next;
  agac_pkg::trace_t             trace_code;

  agac_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign up_s = SCORE_BITS'(in_q.upper_score);
  assign up_x = SCORE_BITS'(in_q.up_ix);

  agac_cell #(.SCORE_BITS(SCORE_BITS)) u_cell (
    .cfg          (cfg),
    .ref_base     (in_q.ref_base),
    .query_base   (in_q.query_base),
    .restart      (in_q.restart),
    .upper_score  (up_s),
    .up_ix        (up_x),
    .left_score   (left_score),
    .left_iy      (left_iy),
    .diag_score   (diag_score),
    .running_best (running_best),
    .cell_score   (cell_score),
    .ix           (ix),
    .iy           (iy),
    .best_next    (best_next),
    .trace_code   (trace_code)
  );

  // input register moves on whenever the result register is free or being drained
  assign move         = in_v && (!out_v || out_ch.ready);
  assign in_ch.ready  = !in_v || move;
  assign take         = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v         <= 1'b0;
      out_v        <= 1'b0;
      left_score   <= '0;
      left_iy      <= '0;
      diag_score   <= '0;
      running_best <= MostNeg;
    end else begin
      if (take) begin
        in_v <= 1'b1;
      end else if (move) begin
        in_v <= 1'b0;
      end
      if (move) begin
        out_v        <= 1'b1;
        left_score   <= cell_score;
        left_iy      <= iy;
        diag_score   <= up_s;
        running_best <= best_next;
      end else if (out_ch.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_q.ref_base    <= in_ch.ref_base;
      in_q.query_base  <= in_ch.query_base;
      in_q.upper_score <= in_ch.upper_score;
      in_q.up_ix       <= in_ch.up_ix;
      in_q.restart     <= in_ch.restart;
    end
    if (move) begin
      out_q.cell_score <= agac_pkg::FIELD_BITS'(cell_score);
      out_q.ix_out     <= agac_pkg::FIELD_BITS'(ix);
      out_q.iy_out     <= agac_pkg::FIELD_BITS'(iy);
      out_q.trace_code <= trace_code;
      out_q.best_score <= agac_pkg::FIELD_BITS'(best_next);
    end
  end

  assign out_ch.valid      = out_v;
  assign out_ch.cell_score = out_q.cell_score;
  assign out_ch.ix_out     = out_q.ix_out;
  assign out_ch.iy_out     = out_q.iy_out;
  assign out_ch.trace_code = out_q.trace_code;
  assign out_ch.best_score = out_q.best_score;

  // after a restart beat the running best is that very cell
  a_restart_best: assert property (@(posedge clk) disable iff (rst)
    move && in_q.restart |=> out_q.best_score == out_q.cell_score)
    else $error("restart beat did not reset running best");

  a_best_covers_cell: assert property (@(posedge clk) disable iff (rst)
    move |=> running_best >= left_score)
    else $error("running best below last cell score");

  a_trace_range: assert property (@(posedge clk) disable iff (rst)
    out_v |-> (out_q.trace_code == agac_pkg::TR_DIAG
            || out_q.trace_code == agac_pkg::TR_LEFT_OPEN
            || out_q.trace_code == agac_pkg::TR_LEFT_EXT
            || out_q.trace_code == agac_pkg::TR_UP_OPEN
            || out_q.trace_code == agac_pkg::TR_UP_EXT))
    else $error("traceback code out of range");

  a_diag_follows_up: assert property (@(posedge clk) disable iff (rst)
    move |=> diag_score == $past(up_s))
    else $error("diagonal not taken from previous up score");

endmodule

/* test/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [15:0] SCORE_FLOOR = 16'sh8000;
  localparam int QUIET_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [agac_pkg::ADDR_BITS-1:0] paddr;
  logic [agac_pkg::DATA_BITS-1:0] pwdata;
  logic [agac_pkg::DATA_BITS-1:0] prdata;
  logic                           pready;

  agac_in_if  in_ch();
  agac_out_if out_ch();

  affine_gap_alignment_cell_core DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk = ~clk;

  // scoring weights as last written
  logic signed [7:0]  award_q;
  logic signed [7:0]  penalty_q;
  logic signed [7:0]  open_q;
  logic signed [7:0]  extend_q;

  // kept state of the cell
  logic signed [15:0] prev_score;
  logic signed [15:0] prev_hgap;
  logic signed [15:0] above_score;
  logic signed [15:0] peak_score;

  agac_pkg::in_item_t  cell_stream[$];
  agac_pkg::out_item_t expected_cells[$];
  agac_pkg::in_item_t  held_item;
  logic                steady_flow;
  int                  mismatch_count;
  int                  quiet_cycles;

  function automatic agac_pkg::out_item_t score_cell(agac_pkg::in_item_t it);
    logic signed [15:0] lopen, lext, uopen, uext;
    logic signed [15:0] hgap, vgap, gap, diag, best;
    agac_pkg::trace_t h_tr, v_tr, g_tr, tr;
    agac_pkg::out_item_t r;
    if (it.restart) begin
      prev_score = '0;
      prev_hgap = '0;
      above_score = '0;
      peak_score = SCORE_FLOOR;
    end
    lopen = prev_score + open_q;
    lext = prev_hgap + extend_q;
    uopen = it.upper_score + open_q;
    uext = it.up_ix + extend_q;
    // ties inside a gap go to the extend side
    if (lopen > lext) begin
      hgap = lopen;
      h_tr = agac_pkg::TR_LEFT_OPEN;
    end else begin
      hgap = lext;
      h_tr = agac_pkg::TR_LEFT_EXT;
    end
    if (uopen > uext) begin
      vgap = uopen;
      v_tr = agac_pkg::TR_UP_OPEN;
    end else begin
      vgap = uext;
      v_tr = agac_pkg::TR_UP_EXT;
    end
    if (hgap > vgap) begin
      gap = hgap;
      g_tr = h_tr;
    end else begin
      gap = vgap;
      g_tr = v_tr;
    end
    diag = above_score + ((it.ref_base == it.query_base) ? award_q : penalty_q);
    if (gap > diag) begin
      best = gap;
      tr = g_tr;
    end else begin
      best = diag;
      tr = agac_pkg::TR_DIAG;
    end
    if (best > peak_score) peak_score = best;
    prev_score = best;
    prev_hgap = hgap;
    above_score = it.upper_score;
    r.cell_score = best;
    r.ix_out = vgap;
    r.iy_out = hgap;
    r.trace_code = tr;
    r.best_score = peak_score;
    return r;
  endfunction

  task automatic add_cell(int rb, int qb, int us, int ux, bit rs);
    agac_pkg::in_item_t c;
    c.ref_base = 2'(rb);
    c.query_base = 2'(qb);
    c.upper_score = 16'(us);
    c.up_ix = 16'(ux);
    c.restart = rs;
    cell_stream.push_back(c);
  endtask

  // mostly rows that start with a restart and follow a drifting column above,
  // with some fully random noise beats
  task automatic queue_random(int count);
    int n, len, lvl, u, ux;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) < 2) begin
        add_cell($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 65535) - 32768,
                 $urandom_range(0, 65535) - 32768, $urandom_range(0, 1));
        n++;
      end else begin
        len = $urandom_range(3, 24);
        case ($urandom_range(0, 3))
          0: lvl = 0;
          1: lvl = 32760;
          2: lvl = -32760;
          default: lvl = $urandom_range(0, 65535) - 32768;
        endcase
        u = lvl;
        for (int k = 0; k < len && n < count; k++) begin
          u = u + $urandom_range(0, 8) - 4;
          case ($urandom_range(0, 2))
            0: ux = u - 1;
            1: ux = u - $urandom_range(0, 40);
            default: ux = $urandom_range(0, 65535) - 32768;
          endcase
          add_cell($urandom_range(0, 3), $urandom_range(0, 3), u, ux, k == 0);
          n++;
        end
      end
    end
  endtask

  task automatic write_reg(agac_pkg::reg_idx_t idx, logic signed [7:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {{24{val[7]}}, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      agac_pkg::REG_MATCH:    award_q = val;
      agac_pkg::REG_MISMATCH: penalty_q = val;
      agac_pkg::REG_GAP_OPEN: open_q = val;
      agac_pkg::REG_GAP_EXT:  extend_q = val;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (cell_stream.size() != 0 || in_ch.valid || expected_cells.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic flag_field(string name, int want, int got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s at %0t: expected %0d, got %0d", name, $realtime, want, got);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) expected_cells.push_back(score_cell(held_item));
      if (!in_ch.valid || in_ch.ready) begin
        if (cell_stream.size() > 0 && (steady_flow || $urandom_range(0, 99) >= 24)) begin
          held_item = cell_stream.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.ref_base <= held_item.ref_base;
          in_ch.query_base <= held_item.query_base;
          in_ch.upper_score <= held_item.upper_score;
          in_ch.up_ix <= held_item.up_ix;
          in_ch.restart <= held_item.restart;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    agac_pkg::out_item_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady_flow || $urandom_range(0, 99) >= 24;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_cells.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("beat at %0t with no cell expected, cell_score %0d", $realtime,
                     out_ch.cell_score);
        end else begin
          want = expected_cells.pop_front();
          if (out_ch.cell_score !== want.cell_score)
            flag_field("cell_score", want.cell_score, out_ch.cell_score);
          if (out_ch.ix_out !== want.ix_out)
            flag_field("ix_out", want.ix_out, out_ch.ix_out);
          if (out_ch.iy_out !== want.iy_out)
            flag_field("iy_out", want.iy_out, out_ch.iy_out);
          if (out_ch.trace_code !== want.trace_code)
            flag_field("trace_code", int'(want.trace_code), int'(out_ch.trace_code));
          if (out_ch.best_score !== want.best_score)
            flag_field("best_score", want.best_score, out_ch.best_score);
        end
      end
    end
  end

  // watchdog on beats in either direction
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("affine_gap_alignment_cell_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic signed [7:0] w_match, w_mis, w_open, w_ext;
    in_ch.valid = 1'b0;
    in_ch.ref_base = '0;
    in_ch.query_base = '0;
    in_ch.upper_score = '0;
    in_ch.up_ix = '0;
    in_ch.restart = 1'b0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    steady_flow = 1'b0;
    mismatch_count = 0;
    quiet_cycles = 0;
    award_q = agac_pkg::MATCH_RESET;
    penalty_q = agac_pkg::MISMATCH_RESET;
    open_q = agac_pkg::GAP_OPEN_RESET;
    extend_q = agac_pkg::GAP_EXT_RESET;
    prev_score = '0;
    prev_hgap = '0;
    above_score = '0;
    peak_score = SCORE_FLOOR;

    // directed cells under the reset weights
    add_cell(0, 0, 0, 0, 1'b1);
    add_cell(1, 2, 5, 4, 1'b0);                // open equals extend from above
    add_cell(3, 3, 32767, 32767, 1'b0);
    add_cell(2, 1, -32768, -32768, 1'b0);      // gap sums wrap around
    add_cell(0, 3, 32767, -32768, 1'b0);
    add_cell(3, 0, -1, -1, 1'b0);
    add_cell(1, 1, 100, 99, 1'b1);             // restart with nonzero state
    add_cell(2, 2, 100, 98, 1'b0);
    for (int k = 0; k < 8; k++) add_cell(k % 4, (k * 3) % 4, k, k - 1, 1'b0);
    add_cell(3, 2, -32768, 32767, 1'b1);
    add_cell(2, 3, 1, 0, 1'b0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: {w_match, w_mis, w_open, w_ext} = {8'sd2, -8'sd3, -8'sd5, -8'sd1};
        1: {w_match, w_mis, w_open, w_ext} = {8'sd127, 8'sd127, 8'sd127, 8'sd127};
        2: {w_match, w_mis, w_open, w_ext} = {-8'sd128, -8'sd128, -8'sd128, -8'sd128};
        3: {w_match, w_mis, w_open, w_ext} = '0;
        4: {w_match, w_mis, w_open, w_ext} = {8'sd127, -8'sd128, -8'sd128, 8'sd127};
        default: {w_match, w_mis, w_open, w_ext} = 32'($urandom);
      endcase
      write_reg(agac_pkg::REG_MATCH, w_match);
      write_reg(agac_pkg::REG_MISMATCH, w_mis);
      write_reg(agac_pkg::REG_GAP_OPEN, w_open);
      write_reg(agac_pkg::REG_GAP_EXT, w_ext);
      steady_flow <= (p == 2);
      queue_random(210);
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_cells.size() == 0) begin
      $display("affine_gap_alignment_cell_core test passed");
    end else begin
      $display("affine_gap_alignment_cell_core test failed");
    end
    $finish;
  end

endmodule
